// ===== rtl/sawa_pkg.sv =====
package sawa_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int HANDLE_BITS = 16;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W      = $clog2(2 * QUEUE_DEPTH);

    // Result queue between the protocol engine and the output stage
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_FRAME   = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    localparam logic DEST_LOWER = 1'b0;
    localparam logic DEST_UPPER = 1'b1;

    // One queued event outcome. When two is set the entry stands for an ack
    // (handle zero, last clear) followed by an upward delivery of handle.
    typedef struct packed {
        logic                   two;
        logic                   dest;
        logic                   is_ack;
        logic                   seq;
        logic [HANDLE_BITS-1:0] handle;
        logic [1:0]             timer;
        logic                   ovf;
    } res_entry_t;

endpackage

// ===== rtl/sawa_front.sv =====
module sawa_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic                            s_frame_is_ack,
    input  logic                            s_frame_seq,
    input  logic [sawa_pkg::HANDLE_BITS-1:0] s_frame_handle,
    output logic                            q_valid,
    input  logic                            q_ready,
    output sawa_pkg::res_entry_t            q_data
);
    import sawa_pkg::*;

    logic              tx_bit_reg, tx_bit_next;
    logic              rx_bit_reg, rx_bit_next;
    logic              waiting_reg, waiting_next;
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic [HANDLE_BITS-1:0] hq_mem [QUEUE_DEPTH];

    logic              accept;
    logic [QSUM_W-1:0] tail_sum;
    logic [QSUM_W-1:0] head_sum;
    logic [QPTR_W-1:0] tail_idx;
    logic [QPTR_W-1:0] head_inc;
    logic [QPTR_W-1:0] rd_idx;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic              push_ok;
    logic              wr_en;
    logic              ack_match;
    logic              emit;
    res_entry_t        entry;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign push_ok = count_reg < QCNT_W'(QUEUE_DEPTH);

    always_comb begin
        tail_sum = QSUM_W'(head_reg) + QSUM_W'(count_reg);
        if (tail_sum >= QSUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - QSUM_W'(QUEUE_DEPTH);
        end
        head_sum = QSUM_W'(head_reg) + QSUM_W'(1);
        if (head_sum >= QSUM_W'(QUEUE_DEPTH)) begin
            head_sum = head_sum - QSUM_W'(QUEUE_DEPTH);
        end
    end

    assign tail_idx  = tail_sum[QPTR_W-1:0];
    assign head_inc  = head_sum[QPTR_W-1:0];
    assign ack_match = waiting_reg && (s_frame_seq == tx_bit_reg) && (count_reg != '0);

    // An ack moves on to the next frame, so read the entry behind the head
    assign rd_idx    = (s_action == ACT_FRAME) ? head_inc : head_reg;
    assign rd_handle = hq_mem[rd_idx];

    always_comb begin
        tx_bit_next  = tx_bit_reg;
        rx_bit_next  = rx_bit_reg;
        waiting_next = waiting_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        emit         = 1'b0;
        entry        = '0;
        if (accept) begin
            unique case (s_action)
                ACT_SEND: begin
                    if (!push_ok) begin
                        emit      = 1'b1;
                        entry.ovf = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + QCNT_W'(1);
                        if (!waiting_reg) begin
                            waiting_next = 1'b1;
                            emit         = 1'b1;
                            entry.dest   = DEST_LOWER;
                            entry.seq    = tx_bit_reg;
                            entry.handle = s_frame_handle;
                            entry.timer  = TMR_START;
                        end
                    end
                end
                ACT_FRAME: begin
                    if (s_frame_is_ack) begin
                        if (ack_match) begin
                            head_next   = head_inc;
                            count_next  = count_reg - QCNT_W'(1);
                            tx_bit_next = ~tx_bit_reg;
                            emit        = 1'b1;
                            if (count_reg == QCNT_W'(1)) begin
                                waiting_next = 1'b0;
                                entry.timer  = TMR_STOP;
                            end else begin
                                entry.seq    = ~tx_bit_reg;
                                entry.handle = rd_handle;
                                entry.timer  = TMR_START;
                            end
                        end
                    end else if (s_frame_seq == rx_bit_reg) begin
                        // ack now, then hand the frame up
                        emit         = 1'b1;
                        entry.two    = 1'b1;
                        entry.is_ack = 1'b1;
                        entry.seq    = rx_bit_reg;
                        entry.handle = s_frame_handle;
                        rx_bit_next  = ~rx_bit_reg;
                    end else begin
                        // duplicate: re-ack the previous bit only
                        emit         = 1'b1;
                        entry.is_ack = 1'b1;
                        entry.seq    = ~rx_bit_reg;
                    end
                end
                ACT_TIMEOUT: begin
                    if (waiting_reg && (count_reg != '0)) begin
                        emit         = 1'b1;
                        entry.seq    = tx_bit_reg;
                        entry.handle = rd_handle;
                        entry.timer  = TMR_START;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign q_valid = emit;
    assign q_data  = entry;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hq_mem[tail_idx] <= s_frame_handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_bit_reg  <= 1'b0;
            rx_bit_reg  <= 1'b0;
            waiting_reg <= 1'b0;
            head_reg    <= '0;
            count_reg   <= '0;
        end else begin
            tx_bit_reg  <= tx_bit_next;
            rx_bit_reg  <= rx_bit_next;
            waiting_reg <= waiting_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== rtl/sawa_fifo.sv =====
module sawa_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sawa_pkg::res_entry_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sawa_pkg::res_entry_t out_data
);
    import sawa_pkg::*;

    res_entry_t            slot_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = count_reg < CMDQ_CNT_W'(CMDQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + CMDQ_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CMDQ_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sawa_back.sv =====
module sawa_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_ready,
    input  sawa_pkg::res_entry_t             q_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_destination,
    output logic                             m_out_is_ack,
    output logic                             m_out_seq,
    output logic [sawa_pkg::HANDLE_BITS-1:0] m_out_handle,
    output logic [1:0]                       m_timer_cmd,
    output logic                             m_queue_overflow,
    output logic                             m_last
);
    import sawa_pkg::*;

    logic                   valid_reg, valid_next;
    logic                   dest_reg, dest_next;
    logic                   is_ack_reg, is_ack_next;
    logic                   seq_reg, seq_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [1:0]             timer_reg, timer_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;
    logic                   dlv_pend_reg, dlv_pend_next;
    logic                   dlv_seq_reg, dlv_seq_next;
    logic [HANDLE_BITS-1:0] dlv_handle_reg, dlv_handle_next;
    logic                   load_ok;

    assign load_ok = !valid_reg || m_ready;
    assign q_ready = load_ok && !dlv_pend_reg;

    always_comb begin
        valid_next      = valid_reg;
        dest_next       = dest_reg;
        is_ack_next     = is_ack_reg;
        seq_next        = seq_reg;
        handle_next     = handle_reg;
        timer_next      = timer_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        dlv_pend_next   = dlv_pend_reg;
        dlv_seq_next    = dlv_seq_reg;
        dlv_handle_next = dlv_handle_reg;
        if (load_ok) begin
            if (dlv_pend_reg) begin
                // second beat of a two-result event: upward delivery
                valid_next    = 1'b1;
                dest_next     = DEST_UPPER;
                is_ack_next   = 1'b0;
                seq_next      = dlv_seq_reg;
                handle_next   = dlv_handle_reg;
                timer_next    = TMR_NONE;
                ovf_next      = 1'b0;
                last_next     = 1'b1;
                dlv_pend_next = 1'b0;
            end else if (q_valid) begin
                valid_next  = 1'b1;
                dest_next   = q_data.dest;
                is_ack_next = q_data.is_ack;
                seq_next    = q_data.seq;
                handle_next = q_data.two ? '0 : q_data.handle;
                timer_next  = q_data.timer;
                ovf_next    = q_data.ovf;
                last_next   = !q_data.two;
                if (q_data.two) begin
                    dlv_pend_next   = 1'b1;
                    dlv_seq_next    = q_data.seq;
                    dlv_handle_next = q_data.handle;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dest_reg       <= dest_next;
        is_ack_reg     <= is_ack_next;
        seq_reg        <= seq_next;
        handle_reg     <= handle_next;
        timer_reg      <= timer_next;
        ovf_reg        <= ovf_next;
        last_reg       <= last_next;
        dlv_seq_reg    <= dlv_seq_next;
        dlv_handle_reg <= dlv_handle_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            dlv_pend_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            dlv_pend_reg <= dlv_pend_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_destination    = dest_reg;
    assign m_out_is_ack     = is_ack_reg;
    assign m_out_seq        = seq_reg;
    assign m_out_handle     = handle_reg;
    assign m_timer_cmd      = timer_reg;
    assign m_queue_overflow = ovf_reg;
    assign m_last           = last_reg;

endmodule

// ===== rtl/stop_and_wait_arq.sv =====
// Alternating-bit stop-and-wait ARQ engine.
// Input channel (s_*): one event per beat. s_action selects a send request
// (s_frame_handle is queued), a frame from the link (s_frame_is_ack,
// s_frame_seq, s_frame_handle), or a retransmit timeout.
// Result channel (m_*): zero, one or two beats per event; m_last marks the
// final beat. A data frame with the expected bit gives an ack beat followed
// by an upward delivery beat. m_timer_cmd tells the external timer to start
// or stop.
// The first result beat of an event is registered in the result queue and
// then in the output register. One event is accepted per cycle while s_ready
// is high; the sustained rate is set by the single result port, so in-order
// data frames, which give two result beats, are slower than other events.
// A two-entry result queue sits between the protocol engine and the output
// register; when m_ready is held low that queue fills and s_ready drops,
// with no event or result lost.
// Reset (aresetn low, synchronous) clears both sequence bits, the waiting
// flag, the pending frame count and all valid flags. The handle store itself
// is not cleared.
module stop_and_wait_arq (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic                             s_frame_is_ack,
    input  logic                             s_frame_seq,
    input  logic [sawa_pkg::HANDLE_BITS-1:0] s_frame_handle,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_destination,
    output logic                             m_out_is_ack,
    output logic                             m_out_seq,
    output logic [sawa_pkg::HANDLE_BITS-1:0] m_out_handle,
    output logic [1:0]                       m_timer_cmd,
    output logic                             m_queue_overflow,
    output logic                             m_last
);
    import sawa_pkg::*;

    logic       fq_valid, fq_ready;
    res_entry_t fq_data;
    logic       bq_valid, bq_ready;
    res_entry_t bq_data;

    sawa_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_frame_is_ack (s_frame_is_ack),
        .s_frame_seq    (s_frame_seq),
        .s_frame_handle (s_frame_handle),
        .q_valid        (fq_valid),
        .q_ready        (fq_ready),
        .q_data         (fq_data)
    );

    sawa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    sawa_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (bq_valid),
        .q_ready          (bq_ready),
        .q_data           (bq_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_destination    (m_destination),
        .m_out_is_ack     (m_out_is_ack),
        .m_out_seq        (m_out_seq),
        .m_out_handle     (m_out_handle),
        .m_timer_cmd      (m_timer_cmd),
        .m_queue_overflow (m_queue_overflow),
        .m_last           (m_last)
    );

    // an ack beat that is not last is followed at once by its delivery beat
    a_dlv_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_destination && !m_out_is_ack))
        else $error("delivery beat missing after ack");

    a_ack_no_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_is_ack) |-> (m_out_handle == '0 && m_timer_cmd == TMR_NONE))
        else $error("ack beat carries handle or timer command");

    a_ovf_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_queue_overflow) |-> (m_last && m_timer_cmd == TMR_NONE &&
                                          m_out_handle == '0))
        else $error("overflow beat carries other fields");

    a_upper_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_destination) |-> m_last)
        else $error("delivery beat not last");

endmodule

// ===== tb/arq_checker.sv =====
`timescale 1ns / 100ps

module arq_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic                             s_frame_is_ack,
    input  logic                             s_frame_seq,
    input  logic [sawa_pkg::HANDLE_BITS-1:0] s_frame_handle,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_destination,
    input  logic                             m_out_is_ack,
    input  logic                             m_out_seq,
    input  logic [sawa_pkg::HANDLE_BITS-1:0] m_out_handle,
    input  logic [1:0]                       m_timer_cmd,
    input  logic                             m_queue_overflow,
    input  logic                             m_last,
    output int                               mismatches,
    output int                               outstanding
);
    import sawa_pkg::*;

    typedef struct packed {
        logic                   dest;
        logic                   is_ack;
        logic                   seq;
        logic [HANDLE_BITS-1:0] handle;
        logic [1:0]             timer;
        logic                   ovf;
        logic                   last;
    } arq_beat_t;

    arq_beat_t expected_beats[$];
    arq_beat_t want;

    // Protocol state as the block should hold it
    logic                   tx_seq;
    logic                   rx_seq;
    logic                   busy;
    logic [HANDLE_BITS-1:0] handle_ring[QUEUE_DEPTH];
    int unsigned            ring_head;
    int unsigned            ring_count;

    function automatic void push_beat(input logic dest, input logic is_ack, input logic seq,
                                      input logic [HANDLE_BITS-1:0] hdl,
                                      input logic [1:0] tmr, input logic ovf,
                                      input logic lst);
        arq_beat_t b;
        b.dest   = dest;
        b.is_ack = is_ack;
        b.seq    = seq;
        b.handle = hdl;
        b.timer  = tmr;
        b.ovf    = ovf;
        b.last   = lst;
        expected_beats.push_back(b);
    endfunction

    task automatic arq_predict(input logic [1:0] act, input logic ack_bit, input logic seq_bit,
                               input logic [HANDLE_BITS-1:0] hdl);
        case (act)
            ACT_SEND: begin
                if (ring_count >= QUEUE_DEPTH) begin
                    push_beat(DEST_LOWER, 1'b0, 1'b0, '0, TMR_NONE, 1'b1, 1'b1);
                end else begin
                    handle_ring[(ring_head + ring_count) % QUEUE_DEPTH] = hdl;
                    ring_count++;
                    if (!busy) begin
                        busy = 1'b1;
                        push_beat(DEST_LOWER, 1'b0, tx_seq, hdl, TMR_START, 1'b0, 1'b1);
                    end
                end
            end
            ACT_FRAME: begin
                if (ack_bit) begin
                    if (busy && seq_bit == tx_seq && ring_count != 0) begin
                        ring_head = (ring_head + 1) % QUEUE_DEPTH;
                        ring_count--;
                        tx_seq = ~tx_seq;
                        if (ring_count == 0) begin
                            busy = 1'b0;
                            push_beat(DEST_LOWER, 1'b0, 1'b0, '0, TMR_STOP, 1'b0, 1'b1);
                        end else begin
                            push_beat(DEST_LOWER, 1'b0, tx_seq, handle_ring[ring_head],
                                      TMR_START, 1'b0, 1'b1);
                        end
                    end
                end else if (seq_bit == rx_seq) begin
                    // in-order data: ack beat, then delivery upward
                    push_beat(DEST_LOWER, 1'b1, rx_seq, '0, TMR_NONE, 1'b0, 1'b0);
                    push_beat(DEST_UPPER, 1'b0, seq_bit, hdl, TMR_NONE, 1'b0, 1'b1);
                    rx_seq = ~rx_seq;
                end else begin
                    push_beat(DEST_LOWER, 1'b1, ~rx_seq, '0, TMR_NONE, 1'b0, 1'b1);
                end
            end
            ACT_TIMEOUT: begin
                if (busy && ring_count != 0) begin
                    push_beat(DEST_LOWER, 1'b0, tx_seq, handle_ring[ring_head],
                              TMR_START, 1'b0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string label, input logic [HANDLE_BITS-1:0] exp_v,
                               input logic [HANDLE_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, label, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tx_seq     = 1'b0;
            rx_seq     = 1'b0;
            busy       = 1'b0;
            ring_head  = 0;
            ring_count = 0;
            mismatches = 0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat expected none, got dest=%0b ack=%0b seq=%0b %s",
                             $time, m_destination, m_out_is_ack, m_out_seq,
                             $sformatf("handle=%h timer=%0d ovf=%0b last=%0b", m_out_handle,
                                       m_timer_cmd, m_queue_overflow, m_last));
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("destination", HANDLE_BITS'(want.dest),
                                HANDLE_BITS'(m_destination));
                    check_field("out_is_ack", HANDLE_BITS'(want.is_ack),
                                HANDLE_BITS'(m_out_is_ack));
                    check_field("out_seq", HANDLE_BITS'(want.seq), HANDLE_BITS'(m_out_seq));
                    check_field("out_handle", want.handle, m_out_handle);
                    check_field("timer_cmd", HANDLE_BITS'(want.timer),
                                HANDLE_BITS'(m_timer_cmd));
                    check_field("queue_overflow", HANDLE_BITS'(want.ovf),
                                HANDLE_BITS'(m_queue_overflow));
                    check_field("last", HANDLE_BITS'(want.last), HANDLE_BITS'(m_last));
                end
            end
            if (s_valid && s_ready) begin
                arq_predict(s_action, s_frame_is_ack, s_frame_seq, s_frame_handle);
            end
        end
        outstanding <= expected_beats.size();
    end

endmodule

// ===== tb/tb_stop_and_wait_arq.sv =====
`timescale 1ns / 100ps

module tb_stop_and_wait_arq;
    import sawa_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RAND_EVENTS = 700;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_action;
    logic                   s_frame_is_ack;
    logic                   s_frame_seq;
    logic [HANDLE_BITS-1:0] s_frame_handle;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_destination;
    logic                   m_out_is_ack;
    logic                   m_out_seq;
    logic [HANDLE_BITS-1:0] m_out_handle;
    logic [1:0]             m_timer_cmd;
    logic                   m_queue_overflow;
    logic                   m_last;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit calm;
    bit hold_req;

    stop_and_wait_arq DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_frame_is_ack   (s_frame_is_ack),
        .s_frame_seq      (s_frame_seq),
        .s_frame_handle   (s_frame_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_destination    (m_destination),
        .m_out_is_ack     (m_out_is_ack),
        .m_out_seq        (m_out_seq),
        .m_out_handle     (m_out_handle),
        .m_timer_cmd      (m_timer_cmd),
        .m_queue_overflow (m_queue_overflow),
        .m_last           (m_last)
    );

    arq_checker u_arq_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_frame_is_ack   (s_frame_is_ack),
        .s_frame_seq      (s_frame_seq),
        .s_frame_handle   (s_frame_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_destination    (m_destination),
        .m_out_is_ack     (m_out_is_ack),
        .m_out_seq        (m_out_seq),
        .m_out_handle     (m_out_handle),
        .m_timer_cmd      (m_timer_cmd),
        .m_queue_overflow (m_queue_overflow),
        .m_last           (m_last),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one event beat; valid stays up after the beat unless a gap follows.
    task automatic send_event(input logic [1:0] act, input logic ack_bit, input logic seq_bit,
                              input logic [HANDLE_BITS-1:0] hdl);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_frame_is_ack <= ack_bit;
        s_frame_seq    <= seq_bit;
        s_frame_handle <= hdl;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic random_event(input int send_pct, output bit counted);
        int r;
        r = $urandom_range(0, 99);
        counted = 1'b1;
        if (r < send_pct) begin
            send_event(ACT_SEND, 1'($urandom()), 1'($urandom()), HANDLE_BITS'($urandom()));
        end else if (r < send_pct + 20) begin
            send_event(ACT_FRAME, 1'b0, 1'($urandom()), HANDLE_BITS'($urandom()));
        end else if (r < send_pct + 28) begin
            send_event(ACT_TIMEOUT, 1'($urandom()), 1'($urandom()), HANDLE_BITS'($urandom()));
        end else if (r < send_pct + 31) begin
            send_event(ACT_UNUSED, 1'($urandom()), 1'($urandom()), HANDLE_BITS'($urandom()));
            counted = 1'b0;
        end else begin
            send_event(ACT_FRAME, 1'b1, 1'($urandom()), HANDLE_BITS'($urandom()));
        end
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off on request
    initial begin
        int  quiet_left;
        bit  held;
        quiet_left = 0;
        held       = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (120) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (!calm && quiet_left == 0 && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                if (quiet_left > 0) quiet_left--;
                else if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 60);
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int send_pct;
        int done_events;
        int iter;
        bit counted;
        bit paused;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_action       <= ACT_SEND;
        s_frame_is_ack <= 1'b0;
        s_frame_seq    <= 1'b0;
        s_frame_handle <= '0;
        calm           <= 1'b0;
        hold_req       <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle corner cases first
        send_event(ACT_FRAME, 1'b1, 1'b0, 16'h1234);     // ack while idle
        send_event(ACT_TIMEOUT, 1'b0, 1'b0, 16'h0000);   // timeout while idle
        send_event(ACT_UNUSED, 1'b0, 1'b0, 16'h0000);
        send_event(ACT_SEND, 1'b0, 1'b0, 16'hFFFF);
        send_event(ACT_SEND, 1'b1, 1'b1, 16'h0000);      // queued behind the first
        send_event(ACT_FRAME, 1'b1, 1'b1, 16'h0000);     // ack with stale bit
        send_event(ACT_TIMEOUT, 1'b1, 1'b1, 16'hFFFF);   // retransmit head
        send_event(ACT_FRAME, 1'b1, 1'b0, 16'hFFFF);     // advance to next frame
        send_event(ACT_FRAME, 1'b1, 1'b1, 16'h0000);     // last ack, stop timer
        send_event(ACT_FRAME, 1'b0, 1'b0, 16'hA5A5);     // in-order data
        send_event(ACT_FRAME, 1'b0, 1'b0, 16'h5A5A);     // duplicate data
        send_event(ACT_FRAME, 1'b0, 1'b1, 16'hFFFF);
        // fill the queue, then one more to overflow
        repeat (QUEUE_DEPTH + 1) send_event(ACT_SEND, 1'b0, 1'b0, HANDLE_BITS'($urandom()));
        send_event(ACT_UNUSED, 1'b1, 1'b1, 16'hFFFF);
        send_event(ACT_TIMEOUT, 1'b0, 1'b1, 16'h8001);

        done_events = 0;
        iter        = 0;
        paused      = 1'b0;
        send_pct    = 30;
        while (done_events < RAND_EVENTS) begin
            if (iter % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_pct = 10;
                    1: send_pct = 30;
                    default: send_pct = 50;
                endcase
            end
            if (done_events == 200) hold_req <= 1'b1;
            if (done_events == 620) calm <= 1'b1;
            if (done_events == 400 && !paused) begin
                paused = 1'b1;
                drain_results();
            end
            random_event(send_pct, counted);
            if (counted) done_events++;
            iter++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
